// File: sv/emm_pkg.sv
package emm_pkg;

  // echo store geometry
  localparam int unsigned EchoFrames = 8192;
  localparam int unsigned EchoAw     = $clog2(EchoFrames);
  localparam int unsigned LenShift   = 9;   // echo length counts 512-frame units

  // FIR
  localparam int unsigned FirTaps = 8;
  localparam int unsigned TapAw   = $clog2(FirTaps);

  // field widths
  localparam int unsigned SampleW = 16;
  localparam int unsigned FrameW  = 2 * SampleW;
  localparam int unsigned HistW   = SampleW - 1;
  localparam int unsigned VolW    = 8;
  localparam int unsigned ProdW   = SampleW + VolW;
  localparam int unsigned FlagsW  = 2;
  localparam int unsigned LenW    = 4;
  localparam int unsigned CoefW   = FirTaps * VolW;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = CoefW;
  localparam int unsigned AccW    = 20;
  localparam int unsigned WideW   = SampleW + 2;

  // control flag bits
  localparam int unsigned FlagMute    = 0;
  localparam int unsigned FlagNoWrite = 1;

  // sequencing
  localparam int unsigned StepW     = 4;
  localparam int unsigned StepMain  = 8;
  localparam int unsigned StepFb    = 9;
  localparam int unsigned StepEvol  = 10;
  localparam int unsigned StepLast  = 11;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMainVolL = 3'd0,
    CfgMainVolR = 3'd1,
    CfgEchoVolL = 3'd2,
    CfgEchoVolR = 3'd3,
    CfgFeedback = 3'd4,
    CfgFlags    = 3'd5,
    CfgLength   = 3'd6,
    CfgCoeffs   = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MulTap,
    MulMain,
    MulFb,
    MulEvol
  } mul_sel_e;

  typedef struct packed {
    logic [1:0][VolW-1:0] mvol;
    logic [1:0][VolW-1:0] evol;
    logic [VolW-1:0]      efb;
    logic [FlagsW-1:0]    flags;
    logic [LenW-1:0]      len;
    logic [CoefW-1:0]     coeffs;
  } cfg_t;

  typedef struct packed {
    logic             clr_wr;     // zero one store frame during the sweep
    logic             start;      // capture word, read frame at position
    logic             load_hist;  // shift the halved frame into histories
    logic             mul_en;
    mul_sel_e         mul_sel;
    logic [TapAw-1:0] tap;
    logic             acc_add;
    logic             fir_ld;
    logic             m_ld;
    logic             w_ld;
    logic             finish;     // write back, advance, load output
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_free;
  } sts_t;

  function automatic logic signed [SampleW-1:0] sat16(input logic signed [WideW-1:0] v);
    logic signed [WideW-1:0] hi;
    logic signed [WideW-1:0] lo;
    hi = WideW'(32767);
    lo = -WideW'(32768);
    if (v > hi) begin
      sat16 = 16'sh7FFF;
    end else if (v < lo) begin
      sat16 = 16'sh8000;
    end else begin
      sat16 = v[SampleW-1:0];
    end
  endfunction

endpackage

// File: sv/emm_ctrl.sv
module emm_ctrl
  import emm_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [1:0] {
    StClear,
    StIdle,
    StLoad,
    StRun
  } state_e;

  state_e           state_q;
  logic [StepW-1:0] step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      step_q  <= '0;
    end else begin
      unique case (state_q)
        StClear: begin
          if (sts_i.clr_last) state_q <= StIdle;
        end
        StIdle: begin
          if (in_valid_i) state_q <= StLoad;
        end
        StLoad: begin
          state_q <= StRun;
          step_q  <= '0;
        end
        StRun: begin
          if (step_q == StepW'(StepLast)) begin
            if (sts_i.out_free) state_q <= StIdle;
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
      endcase
    end
  end

  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    cmd_o           = '0;
    cmd_o.mul_sel   = MulTap;
    cmd_o.tap       = step_q[TapAw-1:0];
    cmd_o.clr_wr    = (state_q == StClear);
    cmd_o.start     = (state_q == StIdle) && in_valid_i;
    cmd_o.load_hist = (state_q == StLoad);
    if (state_q == StRun) begin
      cmd_o.mul_en  = (step_q <= StepW'(StepEvol));
      priority if (step_q < StepW'(StepMain)) cmd_o.mul_sel = MulTap;
      else if (step_q == StepW'(StepMain))    cmd_o.mul_sel = MulMain;
      else if (step_q == StepW'(StepFb))      cmd_o.mul_sel = MulFb;
      else                                    cmd_o.mul_sel = MulEvol;
      cmd_o.acc_add = (step_q != '0) && (step_q < StepW'(FirTaps));
      cmd_o.fir_ld  = (step_q == StepW'(StepMain));
      cmd_o.m_ld    = (step_q == StepW'(StepFb));
      cmd_o.w_ld    = (step_q == StepW'(StepEvol));
      cmd_o.finish  = (step_q == StepW'(StepLast)) && sts_i.out_free;
    end
  end

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StRun |-> step_q <= StepW'(StepLast))
    else $error("step counter ran past the schedule");
  a_accept_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start |=> state_q == StLoad && !in_ready_o)
    else $error("accepted word did not start a frame read");
  a_finish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> sts_i.out_free && cmd_o.mul_en == 1'b0)
    else $error("finish issued while the output register is busy");

endmodule

// File: sv/emm_dp.sv
module emm_dp
  import emm_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cfg_t                      cfg_i,
  input  cmd_t                      cmd_i,
  output sts_t                      sts_o,
  input  logic signed [SampleW-1:0] main_left_i,
  input  logic signed [SampleW-1:0] main_right_i,
  input  logic signed [SampleW-1:0] send_left_i,
  input  logic signed [SampleW-1:0] send_right_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [SampleW-1:0] out_left_o,
  output logic signed [SampleW-1:0] out_right_o
);

  // echo store
  logic [FrameW-1:0] mem [EchoFrames];
  logic [FrameW-1:0] rdata_q;
  logic [EchoAw-1:0] pos_q;
  logic              mem_we;
  logic [FrameW-1:0] mem_wdata;

  // per-channel lanes, 0 = left, 1 = right
  logic signed [HistW-1:0]   hist_q [2][FirTaps];
  logic signed [SampleW-1:0] main_q [2];
  logic signed [SampleW-1:0] send_q [2];
  logic signed [ProdW-1:0]   prod_q [2];
  logic signed [AccW-1:0]    acc_q  [2];
  logic signed [SampleW-1:0] fir_q  [2];
  logic signed [SampleW:0]   m_q    [2];
  logic signed [SampleW-1:0] w_q    [2];
  logic signed [SampleW-1:0] res    [2];
  logic signed [SampleW-1:0] out_q  [2];
  logic                      out_valid_q;

  logic [EchoAw-1:0] pos_inc;
  logic [EchoAw-1:0] pos_lim;

  assign mem_we    = cmd_i.clr_wr || (cmd_i.finish && !cfg_i.flags[FlagNoWrite]);
  assign mem_wdata = cmd_i.clr_wr ? '0 : {w_q[1], w_q[0]};

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[pos_q] <= mem_wdata;
    if (cmd_i.start) rdata_q <= mem[pos_q];
  end

  assign pos_inc = pos_q + 1'b1;
  assign pos_lim = EchoAw'({cfg_i.len, LenShift'(0)});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (cmd_i.clr_wr) begin
      pos_q <= pos_inc;
    end else if (cmd_i.finish) begin
      pos_q <= (pos_inc >= pos_lim) ? '0 : pos_inc;
    end
  end

  assign sts_o.clr_last = (pos_q == '1);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  for (genvar ch = 0; ch < 2; ch++) begin : g_lane
    logic signed [SampleW-1:0] mul_a;
    logic signed [VolW-1:0]    mul_b;
    logic signed [WideW-1:0]   tap_t;   // product >>> 6
    logic signed [SampleW:0]   p7;      // product >>> 7
    logic signed [SampleW-1:0] wrap;
    logic signed [WideW-1:0]   fir_sum;
    logic signed [WideW-1:0]   w_sum;
    logic signed [WideW-1:0]   r_sum;
    logic signed [SampleW-1:0] fir_sat;
    logic signed [SampleW-1:0] w_sat;

    always_comb begin
      unique case (cmd_i.mul_sel)
        MulTap: begin
          mul_a = SampleW'(hist_q[ch][cmd_i.tap]);
          mul_b = cfg_i.coeffs[cmd_i.tap*VolW +: VolW];
        end
        MulMain: begin
          mul_a = main_q[ch];
          mul_b = cfg_i.mvol[ch];
        end
        MulFb: begin
          mul_a = fir_q[ch];
          mul_b = cfg_i.efb;
        end
        MulEvol: begin
          mul_a = fir_q[ch];
          mul_b = cfg_i.evol[ch];
        end
      endcase
    end

    assign tap_t   = prod_q[ch][ProdW-1:6];
    assign p7      = prod_q[ch][ProdW-1:7];
    assign wrap    = acc_q[ch][SampleW-1:0];
    assign fir_sum = WideW'(wrap) + tap_t;
    assign fir_sat = sat16(fir_sum);
    assign w_sum   = WideW'(p7) + WideW'(send_q[ch]);
    assign w_sat   = sat16(w_sum);
    assign r_sum   = WideW'(m_q[ch]) + WideW'(p7);
    assign res[ch] = sat16(r_sum);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        for (int k = 0; k < FirTaps; k++) hist_q[ch][k] <= '0;
      end else if (cmd_i.load_hist) begin
        // oldest in slot 0, newest in the top slot
        for (int k = 0; k < FirTaps - 1; k++) hist_q[ch][k] <= hist_q[ch][k+1];
        hist_q[ch][FirTaps-1] <= rdata_q[ch*SampleW+1 +: HistW];
      end
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.start) begin
        main_q[ch] <= (ch == 0) ? main_left_i : main_right_i;
        send_q[ch] <= (ch == 0) ? send_left_i : send_right_i;
      end
      if (cmd_i.mul_en) prod_q[ch] <= mul_a * mul_b;
      if (cmd_i.load_hist) begin
        acc_q[ch] <= '0;
      end else if (cmd_i.acc_add) begin
        acc_q[ch] <= acc_q[ch] + AccW'(tap_t);
      end
      if (cmd_i.fir_ld) fir_q[ch] <= {fir_sat[SampleW-1:1], 1'b0};
      if (cmd_i.m_ld)   m_q[ch]   <= p7;
      if (cmd_i.w_ld)   w_q[ch]   <= {w_sat[SampleW-1:1], 1'b0};
      if (cmd_i.finish) out_q[ch] <= cfg_i.flags[FlagMute] ? '0 : res[ch];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_left_o  = out_q[0];
  assign out_right_o = out_q[1];

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish && out_valid_q |-> out_ready_i)
    else $error("pending output word overwritten");
  a_write_gate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we && !cmd_i.clr_wr |-> !cfg_i.flags[FlagNoWrite])
    else $error("echo store written while writes are disabled");
  a_sweep_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clr_wr && pos_q == '1 |=> pos_q == '0)
    else $error("clearing sweep did not return to frame zero");

endmodule

// File: sv/echo_fir_master_mixer.sv
// Echo, 8-tap FIR and master mix for one stereo sample per input word.
// Input channel (in_valid_i/in_ready_o): main and echo-send sums, left and
// right. Output channel (out_valid_o/out_ready_i): final stereo sample.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i at the
// clock edge (volumes, feedback, flags, echo length, packed coefficients).
// Words are taken one at a time: a shared multiplier per channel runs the
// eight taps, master volume, feedback and echo volume one after another,
// after the registered echo-RAM read and the history load.
// The registered output word lets the next input be accepted while the
// previous result still waits; if the receiver stalls, the next result
// holds in its last step until the output register frees up.
// Reset: control and configuration registers, histories and position
// clear at once; then the echo RAM is swept to zero, one frame per cycle,
// over 8192 frames, taking configuration writes but no input word.
module echo_fir_master_mixer
  import emm_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CfgIdxW-1:0]        cfg_idx_i,
  input  logic [CfgDataW-1:0]       cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [SampleW-1:0] main_left_i,
  input  logic signed [SampleW-1:0] main_right_i,
  input  logic signed [SampleW-1:0] send_left_i,
  input  logic signed [SampleW-1:0] send_right_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [SampleW-1:0] out_left_o,
  output logic signed [SampleW-1:0] out_right_o
);

  cfg_t cfg_q;
  cmd_t cmd;
  sts_t sts;

  // configuration register file, written only while idle: a rule for the user, the block does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgMainVolL: cfg_q.mvol[0] <= cfg_data_i[VolW-1:0];
        CfgMainVolR: cfg_q.mvol[1] <= cfg_data_i[VolW-1:0];
        CfgEchoVolL: cfg_q.evol[0] <= cfg_data_i[VolW-1:0];
        CfgEchoVolR: cfg_q.evol[1] <= cfg_data_i[VolW-1:0];
        CfgFeedback: cfg_q.efb     <= cfg_data_i[VolW-1:0];
        CfgFlags:    cfg_q.flags   <= cfg_data_i[FlagsW-1:0];
        CfgLength:   cfg_q.len     <= cfg_data_i[LenW-1:0];
        CfgCoeffs:   cfg_q.coeffs  <= cfg_data_i[CoefW-1:0];
      endcase
    end
  end

  // sequencer: clear sweep, accept, history load, twelve-step schedule
  emm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // echo RAM, FIR histories, multipliers, accumulators, output register
  emm_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .main_left_i  (main_left_i),
    .main_right_i (main_right_i),
    .send_left_i  (send_left_i),
    .send_right_i (send_right_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_left_o   (out_left_o),
    .out_right_o  (out_right_o)
  );

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second word accepted while one is in flight");
  a_out_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> ##12 !in_ready_o)
    else $error("word finished earlier than its schedule");
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_left_o)
      && $stable(out_right_o))
    else $error("stalled output word changed");

endmodule

// File: dv/tb.sv
// Self-checking bench for echo_fir_master_mixer.
//
// Flow: reset, then the block clears its echo RAM (no input word taken
// during the sweep). Each test task loads all eight registers while no
// word is in flight, then streams words. A word's expected stereo output is
// computed the moment it is accepted, by a bit-exact software copy of the
// echo/FIR/mix datapath kept in this module (echo RAM, position, histories).
// The output monitor pops the oldest expected word on every output handshake.
//
// Idling schedule: sender 33% / receiver 53% first, then swapped, then none.
// One test holds the receiver off for a long stretch so the block backs up
// into its input.
module tb
  import emm_pkg::*;
;

  localparam int CycleLimit = 400_000;
  localparam int DrainWait  = 20;

  typedef struct packed {
    logic [SampleW-1:0] left;
    logic [SampleW-1:0] right;
  } stereo_t;

  // ---------------------------------------------------------------- DUT I/O
  logic                clk_i;
  logic                rst_ni       = 1'b0;
  logic                cfg_we_i     = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i    = '0;
  logic [CfgDataW-1:0] cfg_data_i   = '0;
  logic                in_valid_i   = 1'b0;
  logic                in_ready_o;
  logic [SampleW-1:0]  main_left_i  = '0;
  logic [SampleW-1:0]  main_right_i = '0;
  logic [SampleW-1:0]  send_left_i  = '0;
  logic [SampleW-1:0]  send_right_i = '0;
  logic                out_valid_o;
  logic                out_ready_i  = 1'b0;
  logic [SampleW-1:0]  out_left_o;
  logic [SampleW-1:0]  out_right_o;

  echo_fir_master_mixer DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .main_left_i  (main_left_i),
    .main_right_i (main_right_i),
    .send_left_i  (send_left_i),
    .send_right_i (send_right_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_left_o   (out_left_o),
    .out_right_o  (out_right_o)
  );

  // ---------------------------------------------------------------- shared state
  int send_idle_pct = 33;
  int recv_idle_pct = 53;
  int hold_left     = 0;       // receiver hold-off, counted down by the monitor
  int mismatches    = 0;
  int cycle_count   = 0;

  stereo_t expected_out_q [$];
  stereo_t exp_word;

  // mirrored registers
  int           mvol [2] = '{0, 0};
  int           evol [2] = '{0, 0};
  int           efb      = 0;
  logic [1:0]   cfg_flags = '0;
  int           echo_len = 0;
  logic [63:0]  coefs    = '0;

  // mirrored datapath state
  logic [31:0]  echo_mem [EchoFrames];
  int           echo_pos = 0;
  int           fir_hist [2][FirTaps];
  int           fir_slot = 0;

  // ---------------------------------------------------------------- clock / timeout
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------- datapath copy
  function automatic int clamp16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int coef(int k);
    return int'($signed(coefs[8*k +: 8]));
  endfunction

  // Newest sample sits in fir_slot and takes coefficient 7; taps 0..6 run
  // oldest-first and their sum wraps to 16 bits before the last tap.
  function automatic int echo_fir_tap_sum(int ch);
    int acc;
    acc = 0;
    for (int k = 0; k < FirTaps - 1; k++)
      acc += (fir_hist[ch][(fir_slot + 1 + k) % FirTaps] * coef(k)) >>> 6;
    acc = int'($signed(acc[15:0]));
    acc += (fir_hist[ch][fir_slot] * coef(FirTaps - 1)) >>> 6;
    return clamp16(acc) & -2;
  endfunction

  function automatic void predict_mix(input logic [15:0] ml, mr, sl, sr);
    int          slot;
    int          fir;
    int          st;
    int          mainv [2];
    int          sendv [2];
    int          mix [2];
    logic [31:0] frame;
    stereo_t     res;
    mainv[0] = int'($signed(ml));
    mainv[1] = int'($signed(mr));
    sendv[0] = int'($signed(sl));
    sendv[1] = int'($signed(sr));
    slot  = echo_pos % EchoFrames;
    frame = echo_mem[slot];
    for (int ch = 0; ch < 2; ch++) begin
      fir_hist[ch][fir_slot] = int'($signed(echo_mem[slot][16*ch +: 16])) >>> 1;
      fir = echo_fir_tap_sum(ch);
      if (!cfg_flags[FlagNoWrite]) begin
        st = clamp16(((fir * efb) >>> 7) + sendv[ch]) & -2;
        frame[16*ch +: 16] = st[15:0];
      end
      mix[ch] = clamp16(((mainv[ch] * mvol[ch]) >>> 7) + ((fir * evol[ch]) >>> 7));
    end
    echo_mem[slot] = frame;
    echo_pos = (echo_pos + 1) & (EchoFrames - 1);
    if (echo_pos >= (echo_len << LenShift)) echo_pos = 0;
    fir_slot = (fir_slot + 1) % FirTaps;
    if (cfg_flags[FlagMute]) begin
      res = '0;
    end else begin
      res.left  = mix[0][15:0];
      res.right = mix[1][15:0];
    end
    expected_out_q.push_back(res);
  endfunction

  // ---------------------------------------------------------------- output monitor
  task automatic note_mismatch(string what, logic [15:0] want, logic [15:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %0d got %0d", what, $signed(want), $signed(got));
  endtask

  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      if (expected_out_q.size() == 0) begin
        note_mismatch("unexpected output word, left", '0, out_left_o);
      end else begin
        exp_word = expected_out_q.pop_front();
        if (out_left_o !== exp_word.left) note_mismatch("left", exp_word.left, out_left_o);
        if (out_right_o !== exp_word.right) note_mismatch("right", exp_word.right, out_right_o);
      end
    end
    // long hold-off first, otherwise random back-pressure
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------- drivers
  // Valid is left high after acceptance; the next call either keeps it up with
  // a new word or drops it for an idle gap.
  task automatic offer_word(input logic [15:0] ml, mr, sl, sr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    main_left_i  <= ml;
    main_right_i <= mr;
    send_left_i  <= sl;
    send_right_i <= sr;
    do @(posedge clk_i); while (!in_ready_o);
    predict_mix(ml, mr, sl, sr);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_out_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [63:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      CfgMainVolL: mvol[0]   = int'($signed(val[7:0]));
      CfgMainVolR: mvol[1]   = int'($signed(val[7:0]));
      CfgEchoVolL: evol[0]   = int'($signed(val[7:0]));
      CfgEchoVolR: evol[1]   = int'($signed(val[7:0]));
      CfgFeedback: efb       = int'($signed(val[7:0]));
      CfgFlags:    cfg_flags = val[1:0];
      CfgLength:   echo_len  = int'(val[3:0]);
      CfgCoeffs:   coefs     = val;
      default: ;
    endcase
  endtask

  // unused upper data bits carry noise; only the register's own bits count
  function automatic logic [63:0] with_noise(logic [63:0] v, int bits);
    logic [63:0] mask;
    mask = (64'd1 << bits) - 64'd1;
    return ({$urandom, $urandom} & ~mask) | (v & mask);
  endfunction

  task automatic load_config(input logic [7:0] mvl, mvr, evl, evr, fb,
                             input logic [1:0] flags, input logic [3:0] len,
                             input logic [63:0] c);
    write_reg(CfgMainVolL, with_noise(64'(mvl), VolW));
    write_reg(CfgMainVolR, with_noise(64'(mvr), VolW));
    write_reg(CfgEchoVolL, with_noise(64'(evl), VolW));
    write_reg(CfgEchoVolR, with_noise(64'(evr), VolW));
    write_reg(CfgFeedback, with_noise(64'(fb), VolW));
    write_reg(CfgFlags,    with_noise(64'(flags), FlagsW));
    write_reg(CfgLength,   with_noise(64'(len), LenW));
    write_reg(CfgCoeffs,   c);
    cfg_we_i <= 1'b0;
  endtask

  // mix of rail values, small values around zero and full-range noise
  function automatic logic [15:0] rand_sample();
    int v;
    case ($urandom_range(3))
      0:       v = $urandom_range(1) ? 32767 : -32768;
      1:       v = int'($urandom_range(511)) - 256;
      default: v = $urandom;
    endcase
    return v[15:0];
  endfunction

  function automatic logic [1:0] rand_flags();
    return ($urandom_range(3) == 0) ? 2'($urandom_range(3)) : 2'b00;
  endfunction

  task automatic run_random_words(int count);
    repeat (count) offer_word(rand_sample(), rand_sample(), rand_sample(), rand_sample());
    drain_results();
  endtask

  // ---------------------------------------------------------------- tests
  // Zero echo length: frame 0 is read and rewritten every word, so the FIR
  // sees its own feedback at once. Rails on every field and volume.
  task automatic test_fir_extremes();
    load_config(8'h7F, 8'h80, 8'h80, 8'h7F, 8'h7F, 2'b00, 4'd0, 64'h807F_807F_7F80_7F80);
    offer_word(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
    offer_word(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
    offer_word(16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000);
    offer_word(16'hFFFF, 16'h0000, 16'h7FFF, 16'h7FFF);
    offer_word(16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000);
    offer_word(16'h0001, 16'hFFFE, 16'h5555, 16'hAAAA);
    offer_word(16'hAAAA, 16'h5555, 16'h0001, 16'hFFFE);
    offer_word(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF);
    drain_results();
    load_config(8'h80, 8'h7F, 8'h7F, 8'h80, 8'h80, 2'b00, 4'd0, 64'h8080_8080_8080_8080);
    offer_word(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
    offer_word(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
    offer_word(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    offer_word(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    offer_word(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    offer_word(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    drain_results();
  endtask

  // mute zeroes the output but echo runs on; no-write freezes the RAM while
  // histories still advance; then both together
  task automatic test_mute_and_no_write();
    load_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                2'(1 << FlagMute), 4'd0, {$urandom, $urandom});
    repeat (3) offer_word(rand_sample(), rand_sample(), rand_sample(), rand_sample());
    drain_results();
    load_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                2'(1 << FlagNoWrite), 4'd0, {$urandom, $urandom});
    repeat (3) offer_word(rand_sample(), rand_sample(), rand_sample(), rand_sample());
    drain_results();
    load_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                2'((1 << FlagMute) | (1 << FlagNoWrite)), 4'd0, {$urandom, $urandom});
    repeat (2) offer_word(rand_sample(), rand_sample(), rand_sample(), rand_sample());
    drain_results();
  endtask

  // length 1 = 512 frames: enough words to wrap the position and read back
  // what was written one lap earlier
  task automatic test_position_wrap();
    load_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                2'b00, 4'd1, {$urandom, $urandom});
    run_random_words(560);
  endtask

  // longest echo with rail gains, then a random length with writes disabled
  task automatic test_long_echo();
    send_idle_pct = 53;
    recv_idle_pct = 33;
    load_config(8'h80, 8'h7F, 8'h7F, 8'h80, 8'h7F, 2'b00, 4'd15, {$urandom, $urandom});
    run_random_words(100);
    load_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                2'(1 << FlagNoWrite), 4'($urandom_range(15)), {$urandom, $urandom});
    run_random_words(100);
  endtask

  // receiver is held off by hold_left while the sender keeps offering: the output
  // register and the last step fill, then input ready drops
  task automatic test_back_pressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    load_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                2'b00, 4'd0, {$urandom, $urandom});
    hold_left = 400;
    run_random_words(60);
  endtask

  // back-to-back at full rate across a few short random settings
  task automatic test_full_rate();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (4) begin
      load_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                  rand_flags(), 4'($urandom_range(3)), {$urandom, $urandom});
      run_random_words(35);
    end
  endtask

  // ---------------------------------------------------------------- sequence
  initial begin
    foreach (echo_mem[i]) echo_mem[i] = '0;
    foreach (fir_hist[c, k]) fir_hist[c][k] = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_fir_extremes();
    test_mute_and_no_write();
    test_position_wrap();
    test_long_echo();
    test_back_pressure();
    test_full_rate();

    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
